/* sv/nec_ir_pkg.sv */
`timescale 1ns / 1ps

package nec_ir_pkg;

   localparam int unsigned WAIT_WIDTH = 18;
   localparam int unsigned CSR_INDEX_WIDTH = 3;

   typedef logic [WAIT_WIDTH-1:0] wait_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_START_WAIT    = 3'd0,
      CSR_LEADER_WAIT_A = 3'd1,
      CSR_LEADER_WAIT_B = 3'd2,
      CSR_LEADER_WAIT_C = 3'd3,
      CSR_BIT_PERIOD    = 3'd4
   } csr_index_type;

   localparam wait_type START_WAIT_RESET    = 18'd90000;
   localparam wait_type LEADER_WAIT_A_RESET = 18'd154000;
   localparam wait_type LEADER_WAIT_B_RESET = 18'd60000;
   localparam wait_type LEADER_WAIT_C_RESET = 18'd71250;
   localparam wait_type BIT_PERIOD_RESET    = 18'd22720;

   localparam logic FUNC_EDGE = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   localparam logic [1:0] STATUS_ACCEPTED = 2'd0;
   localparam logic [1:0] STATUS_OVERLAP  = 2'd1;
   localparam logic [1:0] STATUS_REJECTED = 2'd2;

   typedef struct packed {
      logic func;
      logic ir_level;
   } req_word_type;

   typedef struct packed {
      wait_type   next_wait_cycles;
      logic       frame_done;
      logic [1:0] status;
      logic [7:0] address;
      logic [7:0] command;
   } rsp_word_type;

   typedef struct packed {
      wait_type start_wait;
      wait_type leader_wait_a;
      wait_type leader_wait_b;
      wait_type leader_wait_c;
      wait_type bit_period;
   } cfg_type;

endpackage

/* sv/nec_ir_csr.sv */
`timescale 1ns / 1ps

module nec_ir_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_en,
   input  logic [nec_ir_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  nec_ir_pkg::wait_type                  csr_wdata,
   output nec_ir_pkg::cfg_type                   cfg
);

   nec_ir_pkg::cfg_type cfg_ff;
   nec_ir_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (nec_ir_pkg::csr_index_type'(csr_index))
            nec_ir_pkg::CSR_START_WAIT:    cfg_in.start_wait    = csr_wdata;
            nec_ir_pkg::CSR_LEADER_WAIT_A: cfg_in.leader_wait_a = csr_wdata;
            nec_ir_pkg::CSR_LEADER_WAIT_B: cfg_in.leader_wait_b = csr_wdata;
            nec_ir_pkg::CSR_LEADER_WAIT_C: cfg_in.leader_wait_c = csr_wdata;
            nec_ir_pkg::CSR_BIT_PERIOD:    cfg_in.bit_period    = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_wait    <= nec_ir_pkg::START_WAIT_RESET;
         cfg_ff.leader_wait_a <= nec_ir_pkg::LEADER_WAIT_A_RESET;
         cfg_ff.leader_wait_b <= nec_ir_pkg::LEADER_WAIT_B_RESET;
         cfg_ff.leader_wait_c <= nec_ir_pkg::LEADER_WAIT_C_RESET;
         cfg_ff.bit_period    <= nec_ir_pkg::BIT_PERIOD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* sv/nec_ir_core.sv */
`timescale 1ns / 1ps

module nec_ir_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step_en,
   input  nec_ir_pkg::req_word_type word_in,
   input  nec_ir_pkg::cfg_type      cfg,
   output nec_ir_pkg::rsp_word_type word_out
);

   localparam logic [6:0] LAST_SAMPLE      = 7'd103;
   localparam logic [6:0] SPLIT_SAMPLE     = 7'd52;
   localparam logic [6:0] END_SAMPLE_AFTER = 7'd100;
   localparam logic [6:0] FIRST_BIT_SAMPLE = 7'd5;
   localparam logic [6:0] LAST_BIT_SAMPLE  = 7'd102;
   localparam logic [6:0] LAST_LEADER      = 7'd4;
   localparam logic [7:0] BALANCE_SPACES   = 8'hFE;

   typedef struct packed {
      logic       active;
      logic [6:0] sample_index;
      logic       error_flag;
      logic [7:0] level_balance;
      logic [4:0] bits_taken;
      logic [7:0] shift_true;
      logic [7:0] shift_inverse;
      logic       in_inverse_half;
      logic [7:0] saved_address;
      logic       end_pending;
   } state_type;

   localparam state_type STATE_RESET = '{end_pending: 1'b1, default: '0};

   state_type state_ff;
   state_type state_in;
   nec_ir_pkg::rsp_word_type rsp;

   always_comb begin
      logic [6:0] idx;
      logic       pattern_bit;
      logic       overlap;
      state_in = state_ff;
      rsp = '0;
      idx = state_ff.sample_index;
      pattern_bit = (idx == 7'd3) || (idx == 7'd4);
      overlap = (state_ff.shift_true & state_ff.shift_inverse) != 8'd0;
      if (word_in.func == nec_ir_pkg::FUNC_EDGE) begin
         if (!state_ff.active) begin
            state_in.active = 1'b1;
            state_in.sample_index = '0;
            state_in.error_flag = 1'b0;
            state_in.level_balance = '0;
            state_in.bits_taken = '0;
            state_in.shift_true = '0;
            state_in.shift_inverse = '0;
            state_in.in_inverse_half = 1'b0;
            state_in.end_pending = 1'b1;
            rsp.next_wait_cycles = cfg.start_wait;
         end
      end else if (state_ff.active) begin
         if (state_ff.error_flag || idx >= LAST_SAMPLE) begin
            rsp.frame_done = 1'b1;
            priority if (!state_ff.error_flag && !state_ff.end_pending && !overlap) begin
               rsp.status = nec_ir_pkg::STATUS_ACCEPTED;
            end else if (state_ff.error_flag && overlap) begin
               rsp.status = nec_ir_pkg::STATUS_OVERLAP;
            end else begin
               rsp.status = nec_ir_pkg::STATUS_REJECTED;
            end
            rsp.address = state_ff.saved_address;
            rsp.command = state_ff.shift_true;
            state_in.active = 1'b0;
         end else begin
            if (idx <= LAST_LEADER && word_in.ir_level != pattern_bit) begin
               state_in.error_flag = 1'b1;
            end
            unique case (idx)
               7'd2:    rsp.next_wait_cycles = cfg.leader_wait_a;
               7'd3:    rsp.next_wait_cycles = cfg.leader_wait_b;
               7'd4:    rsp.next_wait_cycles = cfg.leader_wait_c;
               7'd5:    rsp.next_wait_cycles = cfg.bit_period;
               default: rsp.next_wait_cycles = '0;
            endcase
            if (idx >= FIRST_BIT_SAMPLE && idx <= LAST_BIT_SAMPLE) begin
               state_in.level_balance = word_in.ir_level ? state_ff.level_balance - 8'd1
                                                         : state_ff.level_balance + 8'd1;
               if (state_in.level_balance == 8'd0 &&
                   (state_ff.bits_taken == 5'd8 || state_ff.bits_taken == 5'd24)) begin
                  state_in.in_inverse_half = 1'b1;
               end
               if (state_in.level_balance == 8'd0) begin
                  priority if (idx > END_SAMPLE_AFTER) begin
                     state_in.end_pending = 1'b0;
                  end else if (state_in.in_inverse_half) begin
                     state_in.shift_inverse = {state_ff.shift_inverse[6:0], 1'b0};
                  end else begin
                     state_in.shift_true = {state_ff.shift_true[6:0], 1'b0};
                  end
                  state_in.bits_taken = state_ff.bits_taken + 5'd1;
               end else if (state_in.level_balance == BALANCE_SPACES) begin
                  state_in.level_balance = '0;
                  if (state_in.in_inverse_half) begin
                     state_in.shift_inverse[0] = 1'b1;
                  end else begin
                     state_in.shift_true[0] = 1'b1;
                  end
               end
            end
            if (idx == SPLIT_SAMPLE) begin
               if ((state_in.shift_true & state_in.shift_inverse) != 8'd0) begin
                  state_in.error_flag = 1'b1;
               end
               state_in.saved_address = state_in.shift_true;
               state_in.shift_true = '0;
               state_in.shift_inverse = '0;
               state_in.in_inverse_half = 1'b0;
            end
            state_in.sample_index = idx + 7'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else if (step_en) begin
         state_ff <= state_in;
      end
   end

   assign word_out = rsp;

endmodule

/* sv/nec_ir_frame_decoder.sv */
`timescale 1ns / 1ps

// NEC infrared frame decoder working on timed samples of the receiver level.
// A word on the req channel is either a falling-edge event that arms the
// decoder or a sample tick carrying one sampled level. For each req word the
// block returns exactly one rsp word: the next sample interval to load into
// the external timer (zero keeps the period), and on the reporting tick the
// frame_done flag with status, address and command.
// A req word is registered on acceptance; its rsp word is registered once the
// rsp register can advance. One word is taken every cycle while req_stall is
// low; the frame state is updated as each word moves into the rsp register.
// When the receiver stalls, the rsp register holds its word and the input
// register holds one more; req_stall rises only when both are full.
// Reset clears the frame state, both valid flags and loads the default
// intervals. The csr port writes the five interval registers; write them only
// while no word is in flight.
module nec_ir_frame_decoder (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  nec_ir_pkg::req_word_type              req_word,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output nec_ir_pkg::rsp_word_type              rsp_word,
   input  logic                                  csr_write_en,
   input  logic [nec_ir_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  nec_ir_pkg::wait_type                  csr_wdata
);

   nec_ir_pkg::cfg_type      cfg;
   nec_ir_pkg::req_word_type req_word_ff;
   nec_ir_pkg::rsp_word_type rsp_word_ff;
   nec_ir_pkg::rsp_word_type core_word;
   logic                     req_valid_ff;
   logic                     rsp_valid_ff;
   logic                     advance;
   logic                     step_en;

   nec_ir_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   nec_ir_core u_core (
      .clock    (clock),
      .reset    (reset),
      .step_en  (step_en),
      .word_in  (req_word_ff),
      .cfg      (cfg),
      .word_out (core_word)
   );

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign step_en   = req_valid_ff && advance;
   assign req_stall = req_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            rsp_valid_ff <= req_valid_ff;
         end
         if (!req_stall) begin
            req_valid_ff <= req_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         req_word_ff <= req_word;
      end
      if (step_en) begin
         rsp_word_ff <= core_word;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;
   import nec_ir_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int RESET_CYCLES = 12;
   localparam int DRAIN_CYCLES = 8;
   localparam int RANDOM_WORDS = 680;
   localparam int FRAMES_PER_SETTING = 2;
   localparam int HOLD_OFF_CYCLES = 50;
   localparam int MAX_REPORTS = 40;
   localparam int CSR_COUNT = 5;

   localparam logic MARK = 1'b0;
   localparam logic SPACE = 1'b1;
   localparam logic [4:0] LEADER_LEVELS = 5'b11000;
   localparam logic [6:0] FIRST_DATA = 7'd5;
   localparam logic [6:0] SPLIT_SAMPLE = 7'd52;
   localparam logic [6:0] END_MARK_AFTER = 7'd100;
   localparam logic [6:0] LAST_SAMPLE = 7'd103;
   localparam logic [7:0] BALANCE_SURPLUS = 8'hFE;

   typedef enum int {
      FRAME_CLEAN,
      FRAME_ADDR_CLASH,
      FRAME_CMD_CLASH,
      FRAME_NO_END,
      FRAME_BIT_FLIP,
      FRAME_BAD_LEADER,
      FRAME_NOISE
   } frame_kind_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_word_type req_word;
   logic rsp_valid;
   logic rsp_stall;
   rsp_word_type rsp_word;
   logic csr_write_en;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   wait_type csr_wdata;

   // Decoder state as predicted from the accepted words.
   cfg_type dec_cfg;
   logic dec_active;
   logic [6:0] dec_index;
   logic dec_error;
   logic [7:0] dec_balance;
   logic [4:0] dec_bits;
   logic [7:0] dec_true;
   logic [7:0] dec_inverse;
   logic dec_inv_half;
   logic [7:0] dec_saved_address;
   logic dec_end_pending;

   rsp_word_type expected_rsp[$];
   int failures = 0;
   int decoded_words = 0;
   int frames_reported = 0;
   int frames_accepted = 0;
   int settings_loaded = 0;
   int hold_off_left = 0;
   logic steady = 1'b0;

   nec_ir_frame_decoder u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_word     (req_word),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_word     (rsp_word),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic rsp_word_type decode_word(req_word_type w);
      rsp_word_type r;
      logic clash;
      r = '0;
      if (w.func == FUNC_EDGE) begin
         if (!dec_active) begin
            decoded_words++;
            dec_active = 1'b1;
            dec_index = '0;
            dec_error = 1'b0;
            dec_balance = '0;
            dec_bits = '0;
            dec_true = '0;
            dec_inverse = '0;
            dec_inv_half = 1'b0;
            dec_end_pending = 1'b1;
            r.next_wait_cycles = dec_cfg.start_wait;
         end
      end else if (dec_active) begin
         decoded_words++;
         if (dec_error || dec_index >= LAST_SAMPLE) begin
            clash = (dec_true & dec_inverse) != 8'h00;
            r.frame_done = 1'b1;
            if (!dec_error && !dec_end_pending && !clash) begin
               r.status = STATUS_ACCEPTED;
            end else if (dec_error && clash) begin
               r.status = STATUS_OVERLAP;
            end else begin
               r.status = STATUS_REJECTED;
            end
            r.address = dec_saved_address;
            r.command = dec_true;
            dec_active = 1'b0;
         end else begin
            if (dec_index < FIRST_DATA &&
                w.ir_level != LEADER_LEVELS[dec_index[2:0]]) begin
               dec_error = 1'b1;
            end
            case (dec_index)
               7'd2: r.next_wait_cycles = dec_cfg.leader_wait_a;
               7'd3: r.next_wait_cycles = dec_cfg.leader_wait_b;
               7'd4: r.next_wait_cycles = dec_cfg.leader_wait_c;
               7'd5: r.next_wait_cycles = dec_cfg.bit_period;
               default: ;
            endcase
            if (dec_index >= FIRST_DATA && dec_index < LAST_SAMPLE) begin
               dec_balance = (w.ir_level == MARK) ? dec_balance + 8'd1
                                                  : dec_balance - 8'd1;
               if (dec_balance == 8'd0) begin
                  if (dec_bits == 5'd8 || dec_bits == 5'd24) begin
                     dec_inv_half = 1'b1;
                  end
                  if (dec_index > END_MARK_AFTER) begin
                     dec_end_pending = 1'b0;
                  end else if (dec_inv_half) begin
                     dec_inverse = dec_inverse << 1;
                  end else begin
                     dec_true = dec_true << 1;
                  end
                  dec_bits = dec_bits + 5'd1;
               end else if (dec_balance == BALANCE_SURPLUS) begin
                  dec_balance = '0;
                  if (dec_inv_half) begin
                     dec_inverse[0] = 1'b1;
                  end else begin
                     dec_true[0] = 1'b1;
                  end
               end
            end
            if (dec_index == SPLIT_SAMPLE) begin
               if ((dec_true & dec_inverse) != 8'h00) begin
                  dec_error = 1'b1;
               end
               dec_saved_address = dec_true;
               dec_true = '0;
               dec_inverse = '0;
               dec_inv_half = 1'b0;
            end
            dec_index = dec_index + 7'd1;
         end
      end
      return r;
   endfunction

   function automatic req_word_type make_word(logic func, logic level);
      req_word_type w;
      w.func = func;
      w.ir_level = level;
      return w;
   endfunction

   function automatic int idle_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [7:0] random_byte();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return 8'h00;
      if (roll == 1) return 8'hFF;
      return 8'($urandom);
   endfunction

   function automatic frame_kind_type random_kind();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return FRAME_CLEAN;
      if (roll < 63) return FRAME_ADDR_CLASH;
      if (roll < 71) return FRAME_CMD_CLASH;
      if (roll < 79) return FRAME_NO_END;
      if (roll < 87) return FRAME_BIT_FLIP;
      if (roll < 93) return FRAME_BAD_LEADER;
      return FRAME_NOISE;
   endfunction

   // A byte and a near-complement that overlaps it in one bit while keeping
   // the same number of ones, so the frame timing stays aligned.
   function automatic logic [15:0] clash_pair(logic [7:0] b);
      logic [7:0] inv;
      int one_bit;
      int zero_bit;
      if (b == 8'h00 || b == 8'hFF) b = 8'h5A;
      inv = ~b;
      do one_bit = $urandom_range(0, 7); while (!b[one_bit]);
      do zero_bit = $urandom_range(0, 7); while (b[zero_bit]);
      inv[one_bit] = 1'b1;
      inv[zero_bit] = 1'b0;
      return {b, inv};
   endfunction

   function automatic cfg_type interval_setting(int n);
      cfg_type c;
      int roll;
      case (n)
         0: c = '0;
         1: c = '1;
         2: c = {START_WAIT_RESET, LEADER_WAIT_A_RESET, LEADER_WAIT_B_RESET,
                 LEADER_WAIT_C_RESET, BIT_PERIOD_RESET};
         default: begin
            for (int k = 0; k < CSR_COUNT; k++) begin
               roll = $urandom_range(0, 5);
               if (roll == 0) begin
                  c[k*WAIT_WIDTH +: WAIT_WIDTH] = '0;
               end else if (roll == 1) begin
                  c[k*WAIT_WIDTH +: WAIT_WIDTH] = '1;
               end else begin
                  c[k*WAIT_WIDTH +: WAIT_WIDTH] = wait_type'($urandom_range(0, 262143));
               end
            end
         end
      endcase
      return c;
   endfunction

   task automatic send_word(input req_word_type w);
      int gap;
      gap = steady ? 0 : idle_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (req_stall);
      expected_rsp.push_back(decode_word(w));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic load_intervals(input cfg_type c);
      csr_index_type idx;
      wait_type value;
      for (int k = 0; k < CSR_COUNT; k++) begin
         idx = csr_index_type'(k);
         case (idx)
            CSR_START_WAIT:    value = c.start_wait;
            CSR_LEADER_WAIT_A: value = c.leader_wait_a;
            CSR_LEADER_WAIT_B: value = c.leader_wait_b;
            CSR_LEADER_WAIT_C: value = c.leader_wait_c;
            default:           value = c.bit_period;
         endcase
         csr_write_en <= 1'b1;
         csr_index <= idx;
         csr_wdata <= value;
         @(posedge clock);
      end
      csr_write_en <= 1'b0;
      dec_cfg = c;
   endtask

   task automatic send_frame(input frame_kind_type kind, input logic [7:0] addr,
                             input logic [7:0] cmd);
      req_word_type seq[$];
      logic [31:0] payload;
      int first;
      int pos;
      payload = {addr, ~addr, cmd, ~cmd};
      if (kind == FRAME_ADDR_CLASH) payload[31:16] = clash_pair(addr);
      if (kind == FRAME_CMD_CLASH) payload[15:0] = clash_pair(cmd);
      if ($urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 3)) begin
            seq.push_back(make_word(FUNC_TICK, 1'($urandom_range(0, 1))));
         end
      end
      seq.push_back(make_word(FUNC_EDGE, 1'($urandom_range(0, 1))));
      first = seq.size();
      if (kind == FRAME_NOISE) begin
         repeat ($urandom_range(1, 40)) begin
            seq.push_back(make_word(($urandom_range(0, 5) == 0) ? FUNC_EDGE : FUNC_TICK,
                                    1'($urandom_range(0, 1))));
         end
      end else begin
         for (int k = 0; k < 5; k++) seq.push_back(make_word(FUNC_TICK, LEADER_LEVELS[k]));
         for (int k = 31; k >= 0; k--) begin
            seq.push_back(make_word(FUNC_TICK, MARK));
            repeat (payload[k] ? 3 : 1) seq.push_back(make_word(FUNC_TICK, SPACE));
         end
         if (kind != FRAME_NO_END) begin
            seq.push_back(make_word(FUNC_TICK, MARK));
            seq.push_back(make_word(FUNC_TICK, SPACE));
         end
         if (kind == FRAME_BAD_LEADER) begin
            pos = first + $urandom_range(0, 4);
            seq[pos].ir_level = ~seq[pos].ir_level;
         end
         if (kind == FRAME_BIT_FLIP) begin
            pos = $urandom_range(first + 5, seq.size() - 1);
            seq[pos].ir_level = ~seq[pos].ir_level;
         end
      end
      if (seq.size() > first + 2 && $urandom_range(0, 4) == 0) begin
         seq.insert($urandom_range(first + 1, seq.size() - 1),
                    make_word(FUNC_EDGE, 1'($urandom_range(0, 1))));
      end
      foreach (seq[k]) send_word(seq[k]);
      while (dec_active) begin
         send_word(make_word(FUNC_TICK,
                             (kind == FRAME_NO_END) ? SPACE : 1'($urandom_range(0, 1))));
      end
   endtask

   task automatic test_ignored_words_and_leader();
      send_word(make_word(FUNC_TICK, MARK));
      send_word(make_word(FUNC_TICK, SPACE));
      send_word(make_word(FUNC_EDGE, MARK));
      send_word(make_word(FUNC_EDGE, SPACE));
      send_word(make_word(FUNC_TICK, SPACE));
      send_word(make_word(FUNC_TICK, MARK));
      send_word(make_word(FUNC_EDGE, MARK));
      for (int k = 0; k < 4; k++) send_word(make_word(FUNC_TICK, LEADER_LEVELS[k]));
      send_word(make_word(FUNC_TICK, MARK));
      send_word(make_word(FUNC_TICK, SPACE));
   endtask

   task automatic test_receiver_hold_off();
      steady = 1'b1;
      hold_off_left = HOLD_OFF_CYCLES;
      send_frame(FRAME_CLEAN, 8'hA5, 8'h3C);
      steady = 1'b0;
   endtask

   task automatic test_random_frames();
      int word_goal;
      int frames_here;
      word_goal = decoded_words + RANDOM_WORDS;
      frames_here = 0;
      while (decoded_words < word_goal) begin
         if (frames_here % FRAMES_PER_SETTING == 0) begin
            wait_idle();
            load_intervals(interval_setting(settings_loaded));
            settings_loaded++;
         end
         steady = ($urandom_range(0, 4) == 0);
         send_frame(random_kind(), random_byte(), random_byte());
         frames_here++;
      end
      steady = 1'b0;
   endtask

   // Result side: random stall, long hold-off on request, and the checker.
   initial begin
      int stall_left;
      rsp_word_type exp;
      stall_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               failures++;
               if (failures <= MAX_REPORTS) begin
                  $display("%0t ns: rsp word %h arrived with nothing expected",
                           $time, rsp_word);
               end
            end else begin
               exp = expected_rsp.pop_front();
               if (rsp_word !== exp) begin
                  failures++;
                  if (failures <= MAX_REPORTS) begin
                     $display({"%0t ns: rsp mismatch, expected wait=%0d done=%0d ",
                               "status=%0d addr=%h cmd=%h, got wait=%0d done=%0d ",
                               "status=%0d addr=%h cmd=%h"},
                              $time, exp.next_wait_cycles, exp.frame_done, exp.status,
                              exp.address, exp.command, rsp_word.next_wait_cycles,
                              rsp_word.frame_done, rsp_word.status, rsp_word.address,
                              rsp_word.command);
                  end
               end
               if (exp.frame_done) begin
                  frames_reported++;
                  if (exp.status == STATUS_ACCEPTED) frames_accepted++;
               end
            end
         end
         if (hold_off_left > 0) begin
            hold_off_left--;
            rsp_stall <= 1'b1;
         end else if (steady) begin
            rsp_stall <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            stall_left = idle_gap();
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t ns: run exceeded %0d cycles", $time, CYCLE_LIMIT);
      $display("status: fail");
      $finish;
   end

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_word <= '0;
      csr_write_en <= 1'b0;
      csr_index <= CSR_START_WAIT;
      csr_wdata <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      dec_cfg = {START_WAIT_RESET, LEADER_WAIT_A_RESET, LEADER_WAIT_B_RESET,
                 LEADER_WAIT_C_RESET, BIT_PERIOD_RESET};
      dec_active = 1'b0;
      dec_index = '0;
      dec_error = 1'b0;
      dec_balance = '0;
      dec_bits = '0;
      dec_true = '0;
      dec_inverse = '0;
      dec_inv_half = 1'b0;
      dec_saved_address = '0;
      dec_end_pending = 1'b1;

      test_ignored_words_and_leader();
      test_receiver_hold_off();
      test_random_frames();
      wait_idle();

      if (expected_rsp.size() != 0) begin
         failures++;
         $display("%0t ns: %0d rsp words never arrived", $time, expected_rsp.size());
      end
      $display("Decoded %0d words; %0d frames reported, %0d of them accepted.",
               decoded_words, frames_reported, frames_accepted);
      $display({"Interval registers were loaded with %0d settings, ",
                "including all zeros and all ones."},
               settings_loaded);
      if (failures == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

/* nec_ir_frame_decoder.f */
sv/nec_ir_pkg.sv
sv/nec_ir_csr.sv
sv/nec_ir_core.sv
sv/nec_ir_frame_decoder.sv
tb/sv/tb.sv
